// ===== hdl/assert_macros.svh =====
// assertion macros included by the core rtl file
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/cbcm_pkg.sv =====
// shared constants and types for the codebook codeword match and update core
// no dependencies
package cbcm_pkg;

    // field widths
    localparam int unsigned CH_W     = 8;
    localparam int unsigned BRIGHT_W = 9;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MEAN_W   = 16;
    localparam int unsigned NUM_CH   = 3;

    // stream word widths
    localparam int unsigned S_DATA_W = 160;
    localparam int unsigned M_DATA_W = 48;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_THRESHOLD = 2'd0,
        REG_ALPHA           = 2'd1,
        REG_BETA            = 2'd2
    } cfg_reg_t;

    // register reset values
    localparam logic [15:0] THRESH_RST = 16'd8;
    localparam logic [7:0]  ALPHA_RST  = 8'd102;
    localparam logic [8:0]  BETA_RST   = 9'd282;

    // item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

endpackage

// ===== hdl/codebook_codeword_match_update_core.sv =====
// codebook codeword match and update core, top level
// depends on cbcm_pkg and assert_macros.svh
//
// One background codeword is held in registers. A load word (tuser 0) goes from acceptance
// straight to the result state. A test word (tuser 1) runs all its products through one
// shared 16x16 multiplier, one per cycle with a product register, while the color and
// brightness tests run; a decision state follows, and a miss then goes to the result
// state. On a match each channel's new mean, hits times the old mean plus the pixel scaled
// by 256, rounded, is divided by hits+1 in one restoring divider at one quotient bit per
// cycle, each channel taking a multiply step, a setup step and the 16 quotient bits. The
// result state registers the result once the output register is free. The input is
// taken one word at a time. A finished result sits in the output register, so the next
// word can be accepted while it waits.
module codebook_codeword_match_update_core (
    input  logic          clk,
    input  logic          rst_n,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // red, green, blue, bright_low, bright_high, load_count, load_gap, load_first, stamp
    input  logic [cbcm_pkg::S_DATA_W-1:0] s_tdata,
    // op
    input  logic          s_tuser,
    // output stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // hit_count, longest_gap
    output logic [cbcm_pkg::M_DATA_W-1:0] m_tdata,
    // matched
    output logic          m_tuser,
    // configuration
    input  logic          cfg_we,
    input  logic [cbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbcm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cbcm_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DECIDE,
        S_NUM,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] thresh_reg;
    logic [7:0]  alpha_reg;
    logic [8:0]  beta_reg;

    // codeword
    logic [MEAN_W-1:0]   mean_reg [NUM_CH];
    logic [BRIGHT_W-1:0] bmin_reg;
    logic [BRIGHT_W-1:0] bmax_reg;
    logic [COUNT_W-1:0]  hits_reg;
    logic [TIME_W-1:0]   gap_reg;
    logic [TIME_W-1:0]   first_reg;
    logic [TIME_W-1:0]   last_reg;

    // latched input word
    logic                op_reg;
    logic [CH_W-1:0]     px_reg [NUM_CH];
    logic [BRIGHT_W-1:0] blow_reg;
    logic [BRIGHT_W-1:0] bhigh_reg;
    logic [COUNT_W-1:0]  lcount_reg;
    logic [TIME_W-1:0]   lgap_reg;
    logic [TIME_W-1:0]   lfirst_reg;
    logic [TIME_W-1:0]   stamp_reg;

    // sequencer counters
    logic [3:0] step_reg;
    logic [1:0] ch_idx_reg;
    logic [3:0] bit_cnt_reg;

    // test accumulators and flags
    logic [33:0] s_code_reg;
    logic [17:0] s_pix_reg;
    logic        lo_ok_reg;
    logic        hi_ok_reg;
    logic        mn_ok_reg;
    logic        match_reg;

    // shared multiplier
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] prod_reg;
    logic [1:0]  rd_idx;
    logic [MEAN_W-1:0] mean_rd;

    // divider
    logic [16:0] div_d;
    logic [32:0] num;
    logic [16:0] rem_reg;
    logic [15:0] quo_reg;
    logic [17:0] div_t;
    logic        div_ge;
    logic [16:0] rem_next;
    logic [15:0] quo_next;

    // decision and commit values
    logic        color_ok;
    logic [18:0] pix_lim;
    logic [TIME_W-1:0]  gap_now;
    logic [COUNT_W-1:0] hits_next;
    logic [TIME_W-1:0]  gap_next;
    logic        out_free;
    logic        accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // codeword mean read port
    assign rd_idx  = (state_reg == S_TEST) ? step_reg[1:0] : ch_idx_reg;
    assign mean_rd = (rd_idx == 2'd0) ? mean_reg[0] :
                     (rd_idx == 2'd1) ? mean_reg[1] : mean_reg[2];

    // multiplier operand selection
    always_comb
    begin
        mul_a = hits_reg;
        mul_b = mean_rd;
        if (state_reg == S_TEST)
        begin
            case (step_reg)
                4'd0, 4'd1, 4'd2:
                begin
                    mul_a = mean_rd;
                    mul_b = mean_rd;
                end
                4'd3:
                begin
                    mul_a = {8'd0, px_reg[0]};
                    mul_b = {8'd0, px_reg[0]};
                end
                4'd4:
                begin
                    mul_a = {8'd0, px_reg[1]};
                    mul_b = {8'd0, px_reg[1]};
                end
                4'd5:
                begin
                    mul_a = {8'd0, px_reg[2]};
                    mul_b = {8'd0, px_reg[2]};
                end
                4'd6:
                begin
                    mul_a = {8'd0, alpha_reg};
                    mul_b = {7'd0, bmax_reg};
                end
                4'd7:
                begin
                    mul_a = {7'd0, beta_reg};
                    mul_b = {7'd0, bmax_reg};
                end
                4'd8:
                begin
                    mul_a = {7'd0, bhigh_reg};
                    mul_b = {8'd0, alpha_reg};
                end
                default:
                begin
                    mul_a = 16'd0;
                    mul_b = 16'd0;
                end
            endcase
        end
    end

    // rounded numerator and one restoring divider step
    assign div_d    = {1'b0, hits_reg} + 17'd1;
    assign num      = {1'b0, prod_reg} + {17'd0, px_reg[ch_idx_reg], 8'd0}
                      + {17'd0, div_d[16:1]};
    assign div_t    = {rem_reg, quo_reg[15]};
    assign div_ge   = div_t >= {1'b0, div_d};
    assign rem_next = div_ge ? 17'(div_t - {1'b0, div_d}) : div_t[16:0];
    assign quo_next = {quo_reg[14:0], div_ge};

    // color test and commit values
    assign pix_lim   = {1'b0, s_pix_reg} + {3'd0, thresh_reg};
    assign color_ok  = {1'b0, s_code_reg} < {pix_lim, 16'd0};
    assign gap_now   = stamp_reg - last_reg;
    assign hits_next = (hits_reg == {COUNT_W{1'b1}}) ? hits_reg : hits_reg + 16'd1;
    assign gap_next  = (gap_now > gap_reg) ? gap_now : gap_reg;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= 4'd0;
            ch_idx_reg  <= 2'd0;
            bit_cnt_reg <= 4'd0;
            m_tvalid    <= 1'b0;
            m_tuser     <= 1'b0;
            m_tdata     <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    step_reg   <= 4'd0;
                    ch_idx_reg <= 2'd0;
                    if (accept)
                    begin
                        state_reg <= (s_tuser == OP_TEST) ? S_TEST : S_DONE;
                    end
                end
                S_TEST:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd9)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= (color_ok && lo_ok_reg && hi_ok_reg && mn_ok_reg)
                                 ? S_NUM : S_DONE;
                end
                S_NUM:
                begin
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    bit_cnt_reg <= 4'd15;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    bit_cnt_reg <= bit_cnt_reg - 4'd1;
                    if (bit_cnt_reg == 4'd0)
                    begin
                        ch_idx_reg <= ch_idx_reg + 2'd1;
                        state_reg  <= (ch_idx_reg == 2'd2) ? S_DONE : S_NUM;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (op_reg == OP_LOAD)
                        begin
                            m_tuser <= 1'b0;
                            m_tdata <= {lgap_reg, lcount_reg};
                        end
                        else if (match_reg)
                        begin
                            m_tuser <= 1'b1;
                            m_tdata <= {gap_next, hits_next};
                        end
                        else
                        begin
                            m_tuser <= 1'b0;
                            m_tdata <= {gap_reg, hits_reg};
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // configuration, codeword and arithmetic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RST;
            alpha_reg   <= ALPHA_RST;
            beta_reg    <= BETA_RST;
            mean_reg[0] <= '0;
            mean_reg[1] <= '0;
            mean_reg[2] <= '0;
            bmin_reg    <= '0;
            bmax_reg    <= '0;
            hits_reg    <= '0;
            gap_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            s_code_reg  <= '0;
            s_pix_reg   <= '0;
            lo_ok_reg   <= 1'b0;
            hi_ok_reg   <= 1'b0;
            mn_ok_reg   <= 1'b0;
            match_reg   <= 1'b0;
            prod_reg    <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COLOR_THRESHOLD: thresh_reg <= cfg_data;
                    REG_ALPHA:           alpha_reg  <= cfg_data[7:0];
                    REG_BETA:            beta_reg   <= cfg_data[8:0];
                    default:             ;
                endcase
            end

            prod_reg <= mul_a * mul_b;

            if (accept)
            begin
                s_code_reg <= '0;
                s_pix_reg  <= '0;
                match_reg  <= 1'b0;
            end

            // consume the product issued one step earlier
            if (state_reg == S_TEST)
            begin
                case (step_reg)
                    4'd1, 4'd2, 4'd3: s_code_reg <= s_code_reg + {2'd0, prod_reg};
                    4'd4, 4'd5, 4'd6: s_pix_reg  <= s_pix_reg + {2'd0, prod_reg[15:0]};
                    4'd7: lo_ok_reg <= {15'd0, bhigh_reg, 8'd0} > prod_reg;
                    4'd8: hi_ok_reg <= {15'd0, bhigh_reg, 8'd0} < prod_reg;
                    4'd9: mn_ok_reg <= prod_reg < {15'd0, bmin_reg, 8'd0};
                    default: ;
                endcase
            end

            if (state_reg == S_DECIDE)
            begin
                match_reg <= color_ok && lo_ok_reg && hi_ok_reg && mn_ok_reg;
            end

            // divider setup: quotient fits 16 bits so the upper part is below the divisor
            if (state_reg == S_PREP)
            begin
                rem_reg <= num[32:16];
                quo_reg <= num[15:0];
            end

            if (state_reg == S_DIV)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (bit_cnt_reg == 4'd0)
                begin
                    mean_reg[ch_idx_reg] <= quo_next;
                end
            end

            // commit the rest of the codeword
            if (state_reg == S_DONE && out_free)
            begin
                if (op_reg == OP_LOAD)
                begin
                    mean_reg[0] <= {px_reg[0], 8'd0};
                    mean_reg[1] <= {px_reg[1], 8'd0};
                    mean_reg[2] <= {px_reg[2], 8'd0};
                    bmin_reg    <= blow_reg;
                    bmax_reg    <= bhigh_reg;
                    hits_reg    <= lcount_reg;
                    gap_reg     <= lgap_reg;
                    first_reg   <= lfirst_reg;
                    last_reg    <= stamp_reg;
                end
                else if (match_reg)
                begin
                    if (bhigh_reg < bmin_reg)
                    begin
                        bmin_reg <= bhigh_reg;
                    end
                    if (bhigh_reg > bmax_reg)
                    begin
                        bmax_reg <= bhigh_reg;
                    end
                    hits_reg <= hits_next;
                    gap_reg  <= gap_next;
                    last_reg <= stamp_reg;
                end
            end
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            px_reg[0]  <= s_tdata[7:0];
            px_reg[1]  <= s_tdata[15:8];
            px_reg[2]  <= s_tdata[23:16];
            blow_reg   <= s_tdata[32:24];
            bhigh_reg  <= s_tdata[41:33];
            lcount_reg <= s_tdata[57:42];
            lgap_reg   <= s_tdata[89:58];
            lfirst_reg <= s_tdata[121:90];
            stamp_reg  <= s_tdata[153:122];
        end
    end

    // assertions
    `ASSERT_CLK(a_div_rem_below_divisor, (state_reg != S_DIV) || (rem_reg < div_d),
        "divider remainder not below divisor")
    `ASSERT_NEXT(a_accept_starts_work, accept,
        (state_reg == S_TEST) || (state_reg == S_DONE),
        "accepted word did not start work")
    `ASSERT_CLK(a_match_has_hits, !(m_tvalid && m_tuser) || (m_tdata[15:0] != 16'd0),
        "matched result with zero hit count")

endmodule

// ===== tb/codebook_codeword_match_update_core_tb.sv =====
// testbench for the codebook codeword match and update core: directed table then random
// sequences of loads and pixel tests, each result word checked against its table entry or an in-bench predictor
// depends on cbcm_pkg and codebook_codeword_match_update_core
module codebook_codeword_match_update_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbcm_pkg::*;

    // index past the last register, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_WORDS = 292;

    typedef struct packed {
        logic        op;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  blow;
        logic [8:0]  bhigh;
        logic [15:0] cnt;
        logic [31:0] lgap;
        logic [31:0] lfirst;
        logic [31:0] stamp;
    } pix_word_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] hits;
        logic [31:0] gap;
    } cw_result_t;

    typedef struct packed {
        pix_word_t  w;
        logic       known;
        cw_result_t r;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] thr;
        logic [7:0]  alpha;
        logic [8:0]  beta;
    } cfg_set_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted codeword and register copies
    logic [15:0] cw_mean [3];
    logic [8:0]  cw_bmin;
    logic [8:0]  cw_bmax;
    logic [15:0] cw_hits;
    logic [31:0] cw_gap;
    logic [31:0] cw_first;
    logic [31:0] cw_last;
    logic [15:0] set_thresh;
    logic [7:0]  set_alpha;
    logic [8:0]  set_beta;

    cw_result_t pending_results [$];
    int         errors;
    int         words_sent;
    int         results_seen;
    bit         steady;
    logic [31:0] now_stamp;

    codebook_codeword_match_update_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // colour and brightness test, all by cross-multiplication
    function automatic bit pixel_fits(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [8:0] b);
        logic [63:0] s_code;
        logic [63:0] s_pix;
        logic [63:0] b64;
        s_code = 64'(cw_mean[0]) * 64'(cw_mean[0]) + 64'(cw_mean[1]) * 64'(cw_mean[1])
               + 64'(cw_mean[2]) * 64'(cw_mean[2]);
        s_pix  = 64'(c0) * 64'(c0) + 64'(c1) * 64'(c1) + 64'(c2) * 64'(c2);
        b64    = 64'(b);
        return (s_code < ((s_pix + 64'(set_thresh)) << 16))
            && (b64 * 256 > 64'(set_alpha) * 64'(cw_bmax))
            && (b64 * 256 < 64'(set_beta) * 64'(cw_bmax))
            && (b64 * 64'(set_alpha) < 64'(cw_bmin) * 256);
    endfunction

    // load or test one word against the predicted codeword
    function automatic cw_result_t codeword_step(input pix_word_t w);
        cw_result_t  r;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] num;
        logic [7:0]  ch [3];
        logic [31:0] span;
        ch[0] = w.red;
        ch[1] = w.green;
        ch[2] = w.blue;
        r.matched = 1'b0;
        if (w.op == OP_LOAD)
        begin
            for (int i = 0; i < 3; i++)
                cw_mean[i] = {ch[i], 8'h00};
            cw_bmin  = w.blow;
            cw_bmax  = w.bhigh;
            cw_hits  = w.cnt;
            cw_gap   = w.lgap;
            cw_first = w.lfirst;
            cw_last  = w.stamp;
        end
        else if (pixel_fits(w.red, w.green, w.blue, w.bhigh))
        begin
            n    = 64'(cw_hits);
            d    = n + 1;
            span = w.stamp - cw_last;
            // running mean, rounded half up
            for (int i = 0; i < 3; i++)
            begin
                num        = n * 64'(cw_mean[i]) + (64'(ch[i]) << 8);
                cw_mean[i] = 16'((num + d / 2) / d);
            end
            if (w.bhigh < cw_bmin)
                cw_bmin = w.bhigh;
            if (w.bhigh > cw_bmax)
                cw_bmax = w.bhigh;
            if (cw_hits != 16'hFFFF)
                cw_hits = cw_hits + 16'd1;
            if (span > cw_gap)
                cw_gap = span;
            cw_last   = w.stamp;
            r.matched = 1'b1;
        end
        r.hits = cw_hits;
        r.gap  = cw_gap;
        return r;
    endfunction

    function automatic dir_row_t dir_row(input logic op, input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [8:0] blow,
                                         input logic [8:0] bhigh, input logic [15:0] cnt,
                                         input logic [31:0] lgap, input logic [31:0] lfirst,
                                         input logic [31:0] stamp, input logic known,
                                         input logic m, input logic [15:0] h,
                                         input logic [31:0] gap);
        dir_row_t row;
        row.w     = '{op, r, g, b, blow, bhigh, cnt, lgap, lfirst, stamp};
        row.known = known;
        row.r     = '{m, h, gap};
        return row;
    endfunction

    function automatic logic [7:0] clamp8(input int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic logic [8:0] clamp9(input int v);
        return (v < 0) ? 9'd0 : (v > 511) ? 9'd511 : 9'(v);
    endfunction

    // any field any value
    function automatic pix_word_t noise_word();
        pix_word_t w;
        w.op     = 1'($urandom);
        w.red    = 8'($urandom);
        w.green  = 8'($urandom);
        w.blue   = 8'($urandom);
        w.blow   = 9'($urandom);
        w.bhigh  = 9'($urandom);
        w.cnt    = 16'($urandom);
        w.lgap   = $urandom;
        w.lfirst = $urandom;
        w.stamp  = $urandom;
        return w;
    endfunction

    // offer one word, predict once it is taken
    task automatic send_word(input pix_word_t w, input logic known, input cw_result_t fixed);
        int         gap;
        cw_result_t pred;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {6'b0, w.stamp, w.lfirst, w.lgap, w.cnt, w.bhigh, w.blow,
                     w.blue, w.green, w.red};
        do @(posedge clk); while (!s_tready);
        pred = codeword_step(w);
        pending_results.push_back(known ? fixed : pred);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_COLOR_THRESHOLD: set_thresh = data;
            REG_ALPHA:           set_alpha  = data[7:0];
            REG_BETA:            set_beta   = data[8:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // a load followed by pixels near the codeword, or a burst of noise
    task automatic run_sequence();
        pix_word_t w;
        int        ctr;
        int        spread;
        steady = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 5))
                send_word(noise_word(), 1'b0, '0);
        end
        else
        begin
            w        = noise_word();
            w.op     = OP_LOAD;
            ctr      = $urandom_range(8, 511);
            spread   = ctr / 8;
            w.blow   = clamp9(ctr - int'($urandom_range(0, spread)));
            w.bhigh  = clamp9(ctr + int'($urandom_range(0, spread)));
            case ($urandom_range(0, 9))
                0:       w.cnt = 16'hFFFF - 16'($urandom_range(0, 3));
                1:       w.cnt = 16'($urandom);
                default: w.cnt = 16'($urandom_range(0, 40));
            endcase
            if ($urandom_range(0, 3) != 0)
                w.lgap = $urandom_range(0, 2000);
            // some loads sit just below the time wrap
            if ($urandom_range(0, 3) == 0)
                w.stamp = 32'hFFFFFFFF - $urandom_range(0, 3000);
            now_stamp = w.stamp;
            send_word(w, 1'b0, '0);
            repeat ($urandom_range(2, 20))
            begin
                w = noise_word();
                if ($urandom_range(0, 6) != 0)
                begin
                    w.op    = OP_TEST;
                    w.red   = clamp8(int'(cw_mean[0] >> 8) + int'($urandom_range(0, 8)) - 2);
                    w.green = clamp8(int'(cw_mean[1] >> 8) + int'($urandom_range(0, 8)) - 2);
                    w.blue  = clamp8(int'(cw_mean[2] >> 8) + int'($urandom_range(0, 8)) - 2);
                    ctr     = (int'(cw_bmin) + int'(cw_bmax)) / 2;
                    spread  = ctr / 3 + 2;
                    w.bhigh = clamp9(ctr + int'($urandom_range(0, 2 * spread)) - spread);
                    now_stamp = now_stamp + $urandom_range(0, 4000);
                    w.stamp   = now_stamp;
                end
                send_word(w, 1'b0, '0);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // result side: random stalls, one long hold-off, compare in order
    initial
    begin
        int         hold;
        bit         long_done;
        cw_result_t got;
        cw_result_t want;
        long_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 12);
            if (!long_done && results_seen >= 300)
            begin
                hold      = 400;
                long_done = 1'b1;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.matched = m_tuser;
            got.hits    = m_tdata[15:0];
            got.gap     = m_tdata[47:16];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing pending: matched %0b hits %0h gap %0h",
                         $time, got.matched, got.hits, got.gap);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("matched", 32'(want.matched), 32'(got.matched));
                check_field("hit_count", 32'(want.hits), 32'(got.hits));
                check_field("longest_gap", want.gap, got.gap);
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t rows [$];
        cfg_set_t sets [6];
        int       target;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOAD;
        cfg_we    <= 1'b0;
        cfg_index <= REG_COLOR_THRESHOLD;
        cfg_data  <= '0;
        steady       = 1'b0;
        errors       = 0;
        words_sent   = 0;
        results_seen = 0;
        for (int i = 0; i < 3; i++)
            cw_mean[i] = '0;
        cw_bmin    = '0;
        cw_bmax    = '0;
        cw_hits    = '0;
        cw_gap     = '0;
        cw_first   = '0;
        cw_last    = '0;
        set_thresh = THRESH_RST;
        set_alpha  = ALPHA_RST;
        set_beta   = BETA_RST;

        // after reset nothing can match, empty brightness range
        rows.push_back(dir_row(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        rows.push_back(dir_row(OP_TEST, 255, 255, 255, 511, 511, 16'hFFFF, '1, '1, '1,
                               1, 0, 0, 0));
        // all-ones load, then a hit that saturates the count and wraps time
        rows.push_back(dir_row(OP_LOAD, 255, 255, 255, 511, 511, 16'hFFFF, '1, '1, '1,
                               1, 0, 16'hFFFF, '1));
        rows.push_back(dir_row(OP_TEST, 255, 255, 255, 0, 400, 0, 0, 0, 5,
                               1, 1, 16'hFFFF, '1));
        // all-zero load, zero brightness fails the lower test
        rows.push_back(dir_row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        rows.push_back(dir_row(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        // mid codeword: a hit, a dark miss, too bright, too dim
        rows.push_back(dir_row(OP_LOAD, 100, 150, 200, 90, 110, 0, 0, 1000, 1000, 1, 0, 0, 0));
        rows.push_back(dir_row(OP_TEST, 100, 150, 200, 0, 100, 0, 0, 0, 1010, 1, 1, 1, 10));
        rows.push_back(dir_row(OP_TEST, 10, 10, 10, 0, 100, 0, 0, 0, 1020, 1, 0, 1, 10));
        rows.push_back(dir_row(OP_TEST, 100, 150, 200, 0, 200, 0, 0, 0, 1030, 1, 0, 1, 10));
        rows.push_back(dir_row(OP_TEST, 100, 150, 200, 0, 40, 0, 0, 0, 1040, 1, 0, 1, 10));
        rows.push_back(dir_row(OP_TEST, 101, 151, 201, 0, 105, 0, 0, 0, 1100, 0, 0, 0, 0));
        // minimum over alpha is the binding upper limit
        rows.push_back(dir_row(OP_LOAD, 50, 50, 50, 20, 200, 3, 7, 0, 0, 1, 0, 3, 7));
        rows.push_back(dir_row(OP_TEST, 50, 50, 50, 0, 100, 0, 0, 0, 50, 1, 0, 3, 7));
        // colour norm exactly at the threshold misses, one above hits
        rows.push_back(dir_row(OP_LOAD, 0, 0, 3, 100, 100, 0, 0, 0, 0, 1, 0, 0, 0));
        rows.push_back(dir_row(OP_TEST, 0, 0, 1, 0, 100, 0, 0, 0, 4, 1, 0, 0, 0));
        rows.push_back(dir_row(OP_TEST, 0, 1, 1, 0, 100, 0, 0, 0, 9, 1, 1, 1, 9));
        // gap across the time wrap
        rows.push_back(dir_row(OP_LOAD, 60, 70, 80, 100, 100, 10, 5, 0, 32'hFFFFFFF0,
                               1, 0, 10, 5));
        rows.push_back(dir_row(OP_TEST, 60, 70, 80, 0, 100, 0, 0, 0, 32'h10, 1, 1, 11, 32'h20));
        rows.push_back(dir_row(OP_TEST, 61, 71, 81, 0, 104, 0, 0, 0, 32'h30, 0, 0, 0, 0));
        rows.push_back(dir_row(OP_TEST, 255, 0, 128, 0, 255, 0, 0, 0, 32'h40, 0, 0, 0, 0));

        sets[0] = '{16'd8, 8'd102, 9'd282};
        sets[1] = '{16'd0, 8'd1, 9'd256};
        sets[2] = '{16'hFFFF, 8'd255, 9'd511};
        sets[3] = '{16'd40, 8'd0, 9'd300};
        sets[4] = '{16'($urandom_range(0, 200)), 8'($urandom_range(1, 255)),
                    9'($urandom_range(256, 511))};
        sets[5] = '{16'($urandom), 8'($urandom_range(0, 255)), 9'($urandom_range(256, 511))};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table under reset settings
        foreach (rows[k])
            send_word(rows[k].w, rows[k].known, rows[k].r);
        s_tvalid <= 1'b0;
        settle();

        // random phases, registers rewritten while idle
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_COLOR_THRESHOLD, sets[p].thr);
            write_reg(REG_ALPHA, {8'($urandom), sets[p].alpha});
            write_reg(REG_BETA, {7'($urandom), sets[p].beta});
            write_reg(REG_UNUSED, 16'($urandom));
            cfg_we <= 1'b0;
            @(posedge clk);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                run_sequence();
            s_tvalid <= 1'b0;
            steady = 1'b0;
            settle();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cbcm_pkg.sv
hdl/codebook_codeword_match_update_core.sv
tb/codebook_codeword_match_update_core_tb.sv
